@@ sv/bxds_pkg.sv @@
`default_nettype none
package bxds_pkg;

  // fixed field widths
  localparam int CFG_W    = 13;
  localparam int CC_W     = 4;
  localparam int SAMPLE_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W    = 13;
  localparam int CI_W     = 3;
  localparam int SUM_W    = 32;
  localparam int MUL_W    = 14;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DIV_W    = 32;

  // parameter defaults
  localparam int DEF_MAX_WIDTH      = 4096;
  localparam int DEF_MAX_HEIGHT     = 4096;
  localparam int DEF_MAX_COMPONENTS = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_COUNT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_AVG_DIV,
    ST_AVG_WAIT,
    ST_OUT,
    ST_COL_MUL,
    ST_COL_DIV,
    ST_COL_WAIT,
    ST_ROW_MUL,
    ST_ROW_DIV,
    ST_ROW_WAIT,
    ST_RESTART
  } state_t;

  typedef enum logic [1:0] {
    SEL_AREA,
    SEL_COL,
    SEL_ROW
  } op_sel_t;

  typedef struct packed {
    logic    accept;
    logic    update;
    logic    mul_load;
    op_sel_t mul_sel;
    logic    div_start;
    op_sel_t div_sel;
    logic    load_col;
    logic    load_row;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic setup_ok;
    logic restart;
    logic last_cell;
    logic need_col;
    logic need_row;
    logic div_done;
    logic out_free;
  } ctrl_stat_t;

endpackage
`default_nettype wire

@@ sv/bxds_ram.sv @@
`default_nettype none
module bxds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    addr,
  input  wire logic             we,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ sv/bxds_div.sv @@
`default_nettype none
module bxds_div import bxds_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   trial;

  // one restoring step per cycle
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DIV_W-1]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ sv/bxds_ctrl.sv @@
`default_nettype none
module bxds_ctrl import bxds_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   col_r, col_nxt;
  logic   row_r, row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= 1'b0;
      row_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.mul_sel = SEL_AREA;
    cmd.div_sel = SEL_AREA;
    case (state_r)
      ST_IDLE: begin
        in_stall = stat.restart;
        if (in_valid && !stat.restart) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.setup_ok ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        cmd.update   = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = SEL_AREA;
        col_nxt      = stat.need_col;
        row_nxt      = stat.need_row;
        if (stat.last_cell) begin
          state_nxt = ST_AVG_DIV;
        end else if (stat.need_col) begin
          state_nxt = ST_COL_MUL;
        end else if (stat.need_row) begin
          state_nxt = ST_ROW_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_AVG_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_AREA;
        state_nxt     = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (!stat.setup_ok) begin
            state_nxt = ST_IDLE;
          end else if (col_r) begin
            state_nxt = ST_COL_MUL;
          end else if (row_r) begin
            state_nxt = ST_ROW_MUL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COL_MUL: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = SEL_COL;
        state_nxt    = ST_COL_DIV;
      end
      ST_COL_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_COL;
        state_nxt     = ST_COL_WAIT;
      end
      ST_COL_WAIT: begin
        if (stat.div_done) begin
          cmd.load_col = 1'b1;
          col_nxt      = 1'b0;
          state_nxt    = row_r ? ST_ROW_MUL : ST_IDLE;
        end
      end
      ST_ROW_MUL: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = SEL_ROW;
        state_nxt    = ST_ROW_DIV;
      end
      ST_ROW_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_ROW;
        state_nxt     = ST_ROW_WAIT;
      end
      ST_ROW_WAIT: begin
        if (stat.div_done) begin
          cmd.load_row = 1'b1;
          row_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RESTART: begin
        if (stat.setup_ok) begin
          col_nxt   = 1'b1;
          row_nxt   = 1'b1;
          state_nxt = ST_COL_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // a register write restarts the frame
    if (stat.restart) begin
      state_nxt = ST_RESTART;
    end
  end

endmodule
`default_nettype wire

@@ sv/bxds_dp.sv @@
`default_nettype none
module bxds_dp import bxds_pkg::*; #(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [SAMPLE_W-1:0]  in_source_sample,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic      [SAMPLE_W-1:0]  out_average_sample,
  output logic                      out_frame_done,
  output logic                      out_bad_setup,
  input  wire ctrl_cmd_t            cmd,
  output ctrl_stat_t                stat
);

  localparam int DEPTH  = MAX_WIDTH * MAX_COMPONENTS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = POS_W + CC_W + 1;

  // configuration registers
  logic [CFG_W-1:0] sw_r, sh_r, tw_r, th_r;
  logic [CC_W-1:0]  cc_r;
  logic             cfg_hit;
  logic             setup_ok;

  // raster position
  logic [POS_W-1:0] sc_r, sc_nxt, sr_r, sr_nxt;
  logic [POS_W-1:0] tc_r, tc_nxt, tr_r, tr_nxt;
  logic [POS_W-1:0] ce_r, re_r;
  logic [POS_W-1:0] bs_r, bs_nxt, cs_r, cs_nxt;
  logic [CI_W-1:0]  ci_r, ci_nxt;
  logic             need_col, need_row;

  // item registers
  logic [SAMPLE_W-1:0] sample_r;
  logic                bad_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                frame_r;
  logic [PROD_W-1:0]   prod_r;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [DIV_W-1:0]    div_a, div_b;
  logic [DIV_W-1:0]    div_q;
  logic                div_done;
  logic                first, last_cell, last_frame;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic                frame_out_r, bad_out_r;

  // band sum store
  logic [SLOT_W-1:0] slot_full;
  logic [AW-1:0]     addr;
  logic [SUM_W-1:0]  rdata;

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_index)
      REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_TGT_WIDTH, REG_TGT_HEIGHT,
      REG_COMP_COUNT: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= CFG_W'(1);
      sh_r <= CFG_W'(1);
      tw_r <= CFG_W'(1);
      th_r <= CFG_W'(1);
      cc_r <= CC_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  sw_r <= cfg_data;
        REG_SRC_HEIGHT: sh_r <= cfg_data;
        REG_TGT_WIDTH:  tw_r <= cfg_data;
        REG_TGT_HEIGHT: th_r <= cfg_data;
        REG_COMP_COUNT: cc_r <= cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // setup check
  always_comb begin
    setup_ok = (sw_r >= CFG_W'(1)) && (32'(sw_r) <= 32'(MAX_WIDTH)) &&
               (sh_r >= CFG_W'(1)) && (32'(sh_r) <= 32'(MAX_HEIGHT)) &&
               (tw_r >= CFG_W'(1)) && (tw_r <= sw_r) &&
               (th_r >= CFG_W'(1)) && (th_r <= sh_r) &&
               (cc_r >= CC_W'(1)) && (32'(cc_r) <= 32'(MAX_COMPONENTS));
  end

  // store address
  always_comb begin
    slot_full = SLOT_W'(tc_r) * SLOT_W'(cc_r) + SLOT_W'(ci_r);
    if (32'(slot_full) > DEPTH - 1) begin
      addr = AW'(DEPTH - 1);
    end else begin
      addr = AW'(slot_full);
    end
  end

  bxds_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .addr  (addr),
    .we    (cmd.update),
    .wdata (sum_nxt),
    .rdata (rdata)
  );

  // accumulate and cell end checks
  always_comb begin
    first      = (sr_r == bs_r) && (sc_r == cs_r);
    sum_nxt    = first ? SUM_W'(sample_r) : rdata + SUM_W'(sample_r);
    last_cell  = ({1'b0, sr_r} + 14'd1 == {1'b0, re_r}) &&
                 ({1'b0, sc_r} + 14'd1 == {1'b0, ce_r});
    last_frame = ({1'b0, sr_r} + 14'd1 == {1'b0, sh_r}) &&
                 ({1'b0, sc_r} + 14'd1 == {1'b0, sw_r}) &&
                 ({1'b0, ci_r} + CC_W'(1) == cc_r);
  end

  // raster advance
  always_comb begin
    ci_nxt   = ci_r;
    sc_nxt   = sc_r;
    sr_nxt   = sr_r;
    tc_nxt   = tc_r;
    tr_nxt   = tr_r;
    bs_nxt   = bs_r;
    cs_nxt   = cs_r;
    need_col = 1'b0;
    need_row = 1'b0;
    if ({1'b0, ci_r} + CC_W'(1) >= cc_r) begin
      ci_nxt = '0;
      if ({1'b0, sc_r} + 14'd1 >= {1'b0, ce_r}) begin
        cs_nxt   = ce_r;
        tc_nxt   = tc_r + POS_W'(1);
        need_col = 1'b1;
        if (tc_r + POS_W'(1) >= tw_r) begin
          tc_nxt = '0;
          cs_nxt = '0;
        end
      end
      sc_nxt = sc_r + POS_W'(1);
      if ({1'b0, sc_r} + 14'd1 >= {1'b0, sw_r}) begin
        sc_nxt   = '0;
        tc_nxt   = '0;
        cs_nxt   = '0;
        need_col = 1'b1;
        if ({1'b0, sr_r} + 14'd1 >= {1'b0, re_r}) begin
          bs_nxt   = re_r;
          tr_nxt   = tr_r + POS_W'(1);
          need_row = 1'b1;
          if (tr_r + POS_W'(1) >= th_r) begin
            tr_nxt = '0;
            bs_nxt = '0;
          end
        end
        sr_nxt = sr_r + POS_W'(1);
        if ({1'b0, sr_r} + 14'd1 >= {1'b0, sh_r}) begin
          sr_nxt   = '0;
          tr_nxt   = '0;
          bs_nxt   = '0;
          need_row = 1'b1;
        end
      end
    end else begin
      ci_nxt = ci_r + CI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r <= '0;
      sc_r <= '0;
      sr_r <= '0;
      tc_r <= '0;
      tr_r <= '0;
      bs_r <= '0;
      cs_r <= '0;
      ce_r <= POS_W'(1);
      re_r <= POS_W'(1);
    end else if (cfg_hit) begin
      ci_r <= '0;
      sc_r <= '0;
      sr_r <= '0;
      tc_r <= '0;
      tr_r <= '0;
      bs_r <= '0;
      cs_r <= '0;
      ce_r <= '0;
      re_r <= '0;
    end else begin
      if (cmd.update) begin
        ci_r <= ci_nxt;
        sc_r <= sc_nxt;
        sr_r <= sr_nxt;
        tc_r <= tc_nxt;
        tr_r <= tr_nxt;
        bs_r <= bs_nxt;
        cs_r <= cs_nxt;
      end
      if (cmd.load_col) begin
        ce_r <= div_q[POS_W-1:0];
      end
      if (cmd.load_row) begin
        re_r <= div_q[POS_W-1:0];
      end
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      SEL_COL: begin
        mul_a = {1'b0, tc_r} + MUL_W'(1);
        mul_b = MUL_W'(sw_r);
      end
      SEL_ROW: begin
        mul_a = {1'b0, tr_r} + MUL_W'(1);
        mul_b = MUL_W'(sh_r);
      end
      default: begin
        mul_a = MUL_W'(re_r - bs_r);
        mul_b = MUL_W'(ce_r - cs_r);
      end
    endcase
  end

  // divider operands
  always_comb begin
    case (cmd.div_sel)
      SEL_COL: begin
        div_a = DIV_W'(prod_r);
        div_b = DIV_W'(tw_r);
      end
      SEL_ROW: begin
        div_a = DIV_W'(prod_r);
        div_b = DIV_W'(th_r);
      end
      default: begin
        div_a = sum_r;
        div_b = DIV_W'(prod_r);
      end
    endcase
  end

  bxds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // item payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_source_sample;
      bad_r    <= !setup_ok;
    end
    if (cmd.update) begin
      sum_r   <= sum_nxt;
      frame_r <= last_frame;
    end
    if (cmd.mul_load) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (bad_r) begin
        avg_r <= '0;
      end else if (div_q[DIV_W-1:SAMPLE_W] != '0) begin
        avg_r <= '1;
      end else begin
        avg_r <= div_q[SAMPLE_W-1:0];
      end
      frame_out_r <= !bad_r && frame_r;
      bad_out_r   <= bad_r;
    end
  end

  always_comb begin
    stat.setup_ok  = setup_ok;
    stat.restart   = cfg_hit;
    stat.last_cell = last_cell;
    stat.need_col  = need_col;
    stat.need_row  = need_row;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid          = out_valid_r;
  assign out_average_sample = avg_r;
  assign out_frame_done     = frame_out_r;
  assign out_bad_setup      = bad_out_r;

endmodule
`default_nettype wire

@@ sv/box_average_downsampler.sv @@
// Box-average downscaler for an interleaved 8-bit image.
// Input channel: in_valid / in_stall carry one source component sample per beat,
// raster order, components interleaved. Result channel: out_valid / out_stall
// carry one averaged sample per finished cell and component, with frame_done on
// the last sample of the frame and bad_setup when the geometry is unusable.
// Config port: cfg_we / cfg_index / cfg_data; any write to a known register
// restarts the frame and recomputes the first cell edges (input stalled
// meanwhile). Write only while no beat is in flight.
// Samples are taken one at a time: input stalls until the current one is done.
// A cell-ending sample adds a serial 32-bit divide of the sum by the cell area;
// crossing a column or row cell edge adds one divide each, of (t+1)*S by T for
// the next edge on the same divider.
// A result is held in an output register until taken; when the receiver stalls,
// the block finishes the current beat and waits before loading the next result.
// Reset: all registers read 1, position at frame start, no result pending. The
// band sum store is not cleared: the first sample of each cell overwrites it.
`default_nettype none
module box_average_downsampler import bxds_pkg::*; #(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  in_source_sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [SAMPLE_W-1:0]  out_average_sample,
  output logic                      out_frame_done,
  output logic                      out_bad_setup
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencer
  bxds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath with band store and divider
  bxds_dp #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_source_sample   (in_source_sample),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_average_sample (out_average_sample),
    .out_frame_done     (out_frame_done),
    .out_bad_setup      (out_bad_setup),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule
`default_nettype wire

@@ tb/sv/box_average_downsampler_test.sv @@
`timescale 1ns / 100ps
module box_average_downsampler_test;
  import bxds_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int MAX_C = DEF_MAX_COMPONENTS;
  localparam int SUM_DEPTH = MAX_W * MAX_C;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_COMP_COUNT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct {
    logic [SAMPLE_W-1:0] average;
    logic                frame_done;
    logic                bad_setup;
  } cell_result_t;

  // predicts one result per finished cell and component, or one bad-setup result per sample
  class avg_scoreboard;
    int unsigned src_w, src_h, tgt_w, tgt_h, comps;
    bit [31:0] cell_sums [];
    int unsigned col, row, comp, tcol, trow, col_edge, row_edge, band_row, cell_col;
    cell_result_t due_q[$];
    int errors;

    function new();
      cell_sums = new[SUM_DEPTH];
      src_w = 1; src_h = 1; tgt_w = 1; tgt_h = 1; comps = 1;
      errors = 0;
      restart();
    endfunction

    function bit geometry_ok();
      return src_w >= 1 && src_w <= MAX_W && src_h >= 1 && src_h <= MAX_H &&
             tgt_w >= 1 && tgt_w <= src_w && tgt_h >= 1 && tgt_h <= src_h &&
             comps >= 1 && comps <= MAX_C;
    endfunction

    function int unsigned cell_end(int unsigned t, int unsigned src, int unsigned tgt);
      longint unsigned prod;
      if (tgt == 0) return 0;
      prod = longint'(t + 1) * longint'(src);
      return int'(prod / tgt);
    endfunction

    function void restart();
      col = 0; row = 0; comp = 0; tcol = 0; trow = 0; band_row = 0; cell_col = 0;
      if (geometry_ok()) begin
        col_edge = cell_end(0, src_w, tgt_w);
        row_edge = cell_end(0, src_h, tgt_h);
      end else begin
        col_edge = 0;
        row_edge = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SRC_WIDTH: src_w = data;
        REG_SRC_HEIGHT: src_h = data;
        REG_TGT_WIDTH: tgt_w = data;
        REG_TGT_HEIGHT: tgt_h = data;
        REG_COMP_COUNT: comps = data[CC_W-1:0];
        default: return;
      endcase
      restart();
    endfunction

    // accepted input beat
    function void note_sample(logic [SAMPLE_W-1:0] sample);
      int unsigned slot, area, avg;
      cell_result_t r;
      if (!geometry_ok()) begin
        r.average = '0; r.frame_done = 1'b0; r.bad_setup = 1'b1;
        due_q.push_back(r);
        return;
      end
      slot = tcol * comps + comp;
      if (slot >= SUM_DEPTH) slot = SUM_DEPTH - 1;
      if (row == band_row && col == cell_col) cell_sums[slot] = sample;
      else cell_sums[slot] = cell_sums[slot] + sample;
      if (row + 1 == row_edge && col + 1 == col_edge) begin
        area = (row_edge - band_row) * (col_edge - cell_col);
        avg = (area != 0) ? cell_sums[slot] / area : 0;
        if (avg > 255) avg = 255;
        r.average = avg[SAMPLE_W-1:0];
        r.frame_done = (row + 1 == src_h) && (col + 1 == src_w) && (comp + 1 == comps);
        r.bad_setup = 1'b0;
        due_q.push_back(r);
      end
      // advance raster position
      comp++;
      if (comp >= comps) begin
        comp = 0;
        if (col + 1 >= col_edge) begin
          cell_col = col_edge;
          tcol++;
          if (tcol >= tgt_w) begin
            tcol = 0;
            cell_col = 0;
          end
          col_edge = cell_end(tcol, src_w, tgt_w);
        end
        col++;
        if (col >= src_w) begin
          col = 0; tcol = 0; cell_col = 0;
          col_edge = cell_end(0, src_w, tgt_w);
          if (row + 1 >= row_edge) begin
            band_row = row_edge;
            trow++;
            if (trow >= tgt_h) begin
              trow = 0;
              band_row = 0;
            end
            row_edge = cell_end(trow, src_h, tgt_h);
          end
          row++;
          if (row >= src_h) restart();
        end
      end
    endfunction

    // accepted output beat
    function void check_result(logic [SAMPLE_W-1:0] average, logic done, logic bad);
      cell_result_t e;
      if (due_q.size() == 0) begin
        $error("unexpected result beat: average %0d done %0b bad %0b", average, done, bad);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (average !== e.average) begin
        $error("average_sample: expected %0d, got %0d", e.average, average);
        errors++;
      end
      if (done !== e.frame_done) begin
        $error("frame_done: expected %0b, got %0b", e.frame_done, done);
        errors++;
      end
      if (bad !== e.bad_setup) begin
        $error("bad_setup: expected %0b, got %0b", e.bad_setup, bad);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_source_sample;
  logic out_valid;
  logic out_stall;
  logic [SAMPLE_W-1:0] out_average_sample;
  logic out_frame_done;
  logic out_bad_setup;

  avg_scoreboard sb = new();
  bit calm;
  int quiet_cycles;
  int sent;

  box_average_downsampler i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_source_sample(in_source_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_average_sample(out_average_sample), .out_frame_done(out_frame_done),
    .out_bad_setup(out_bad_setup)
  );

  // clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_average_sample, out_frame_done, out_bad_setup);
  end

  // watchdog on cycles with no accepted beat or write
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stalls a random number of cycles per beat
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write enable stays high across back to back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic load_geometry(int sw, int sh, int tw, int th, int cc);
    settle();
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI), $urandom_range(0, 8191));
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_TGT_WIDTH, tw);
    write_reg(REG_TGT_HEIGHT, th);
    write_reg(REG_COMP_COUNT, cc);
    cfg_we <= 1'b0;
  endtask

  // fill below zero means random samples with frequent extremes
  task automatic send_samples(int count, int fill);
    int gap;
    logic [SAMPLE_W-1:0] s;
    gap = calm ? 0 : $urandom_range(0, 8);
    for (int k = 0; k < count; k++) begin
      if (gap > 0) repeat (gap) @(posedge clk);
      if (fill >= 0) s = fill;
      else case ($urandom_range(0, 7))
        0: s = '0;
        1: s = '1;
        default: s = $urandom_range(0, 255);
      endcase
      in_valid <= 1'b1;
      in_source_sample <= s;
      do @(posedge clk); while (in_stall);
      sb.note_sample(s);
      sent++;
      // drop valid before an idle gap or after the last beat
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0 || k == count - 1) in_valid <= 1'b0;
    end
    @(posedge clk);
  endtask

  initial begin
    int sw, sh, tw, th, cc, frame;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_source_sample = '0;
    calm = 1'b0;
    quiet_cycles = 0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: one-pixel frames
    send_samples(1, 0);
    send_samples(1, 255);
    // small frame of full-scale samples, two components
    load_geometry(3, 2, 2, 1, 2);
    send_samples(12, 255);
    // unusable geometries
    load_geometry(0, 1, 1, 1, 1);
    send_samples(1, -1);
    load_geometry(8191, 1, 1, 1, 1);
    send_samples(1, -1);
    load_geometry(2, 1, 3, 1, 1);
    send_samples(1, -1);
    load_geometry(1, 2, 1, 3, 1);
    send_samples(1, -1);
    load_geometry(1, 1, 1, 1, 0);
    send_samples(1, -1);
    load_geometry(1, 1, 1, 1, 15);
    send_samples(1, -1);
    // component count written with high don't-care bits
    load_geometry(2, 2, 1, 1, 13'h1FF8);
    send_samples(2, -1);

    // widest source in wide cells, full scale, partial frame
    calm = 1'b1;
    load_geometry(MAX_W, 1, MAX_W / 32, 1, 1);
    send_samples(64, 255);
    calm = 1'b0;
    // widest target and all components, partial frame
    load_geometry(MAX_W, MAX_H, MAX_W, MAX_H, MAX_C);
    send_samples(60, -1);
    // tallest target, one column
    load_geometry(1, MAX_H, 1, MAX_H, 1);
    send_samples(40, -1);

    // random small geometries, mostly whole frames
    while (sent < 400) begin
      calm = ($urandom_range(0, 4) == 0);
      sw = $urandom_range(1, 6);
      sh = $urandom_range(1, 3);
      tw = $urandom_range(1, sw);
      th = $urandom_range(1, sh);
      cc = $urandom_range(1, MAX_C);
      if ($urandom_range(0, 11) == 0) tw = sw + 1;
      load_geometry(sw, sh, tw, th, cc);
      frame = sw * sh * cc;
      case ($urandom_range(0, 5))
        0: send_samples($urandom_range(1, frame), -1);
        1: send_samples(2 * frame, -1);
        default: send_samples(frame, -1);
      endcase
    end

    // drain
    calm = 1'b0;
    settle();
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ box_average_downsampler.f @@
sv/bxds_pkg.sv
sv/bxds_ram.sv
sv/bxds_div.sv
sv/bxds_ctrl.sv
sv/bxds_dp.sv
sv/box_average_downsampler.sv
tb/sv/box_average_downsampler_test.sv
